/* rtl/hanging_plotter_point_to_cord_lengths_macros.svh */
// assertion helpers used by the checker file
`ifndef HANGING_PLOTTER_POINT_TO_CORD_LENGTHS_MACROS_SVH
`define HANGING_PLOTTER_POINT_TO_CORD_LENGTHS_MACROS_SVH

// same-cycle implication, reset masked
`define HPC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, reset masked
`define HPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/hpc_pkg.sv */
package hpc_pkg;

  // default fixed-point fraction width
  localparam int FRACTION_BITS = 8;

  // result field widths
  localparam int PT_W  = 16;
  localparam int DIV_W = 8;
  localparam int LEN_W = 26;
  localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

  // register map
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_X_DIV   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_DIV   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ORG_X   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ORG_Y   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPACING = 3'd4;

  // result commands
  typedef enum logic [1:0] {
    CMD_MOVE     = 2'd0,
    CMD_PEN_DOWN = 2'd1,
    CMD_PEN_UP   = 2'd2
  } cmd_t;

  // control that rides along with a point through the cells
  typedef struct packed {
    logic valid;
    logic start;
    logic stop;
  } meta_t;

endpackage

/* rtl/hpc_div_cell.sv */
// one restoring division step for both x and y
module hpc_div_cell #(
  parameter int NW = 24
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  hpc_pkg::meta_t              meta_i,
  input  logic [NW-1:0]               nx_i,
  input  logic [hpc_pkg::DIV_W-1:0]   rx_i,
  input  logic [NW-1:0]               qx_i,
  input  logic [NW-1:0]               ny_i,
  input  logic [hpc_pkg::DIV_W-1:0]   ry_i,
  input  logic [NW-1:0]               qy_i,
  input  logic [hpc_pkg::DIV_W-1:0]   dvx,
  input  logic [hpc_pkg::DIV_W-1:0]   dvy,
  output hpc_pkg::meta_t              meta_o,
  output logic [NW-1:0]               nx_o,
  output logic [hpc_pkg::DIV_W-1:0]   rx_o,
  output logic [NW-1:0]               qx_o,
  output logic [NW-1:0]               ny_o,
  output logic [hpc_pkg::DIV_W-1:0]   ry_o,
  output logic [NW-1:0]               qy_o
);

  localparam int DW = hpc_pkg::DIV_W;

  hpc_pkg::meta_t meta_r;
  logic [NW-1:0]  nx_r, qx_r, ny_r, qy_r;
  logic [DW-1:0]  rx_r, ry_r;
  logic [DW:0]    tx, ty;
  logic           gex, gey;
  logic [DW-1:0]  rx_nxt, ry_nxt;

  // shift in next dividend bit and try subtracting
  always_comb begin
    tx     = {rx_i, nx_i[NW-1]};
    ty     = {ry_i, ny_i[NW-1]};
    gex    = tx >= {1'b0, dvx};
    gey    = ty >= {1'b0, dvy};
    rx_nxt = gex ? DW'(tx - {1'b0, dvx}) : tx[DW-1:0];
    ry_nxt = gey ? DW'(ty - {1'b0, dvy}) : ty[DW-1:0];
  end

  // control register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meta_r <= '0;
    end else if (en) begin
      meta_r <= meta_i;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (en) begin
      nx_r <= nx_i << 1;
      ny_r <= ny_i << 1;
      rx_r <= rx_nxt;
      ry_r <= ry_nxt;
      qx_r <= {qx_i[NW-2:0], gex};
      qy_r <= {qy_i[NW-2:0], gey};
    end
  end

  assign meta_o = meta_r;
  assign nx_o   = nx_r;
  assign rx_o   = rx_r;
  assign qx_o   = qx_r;
  assign ny_o   = ny_r;
  assign ry_o   = ry_r;
  assign qy_o   = qy_r;

endmodule

/* rtl/hpc_sqrt_cell.sv */
// one digit of integer square root for both cords
module hpc_sqrt_cell #(
  parameter int RW = 26
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  hpc_pkg::meta_t    meta_i,
  input  logic [2*RW-1:0]   vl_i,
  input  logic [RW+1:0]     rl_i,
  input  logic [RW-1:0]     ql_i,
  input  logic [2*RW-1:0]   vr_i,
  input  logic [RW+1:0]     rr_i,
  input  logic [RW-1:0]     qr_i,
  output hpc_pkg::meta_t    meta_o,
  output logic [2*RW-1:0]   vl_o,
  output logic [RW+1:0]     rl_o,
  output logic [RW-1:0]     ql_o,
  output logic [2*RW-1:0]   vr_o,
  output logic [RW+1:0]     rr_o,
  output logic [RW-1:0]     qr_o
);

  localparam int VW = 2 * RW;

  hpc_pkg::meta_t  meta_r;
  logic [VW-1:0]   vl_r, vr_r;
  logic [RW+1:0]   rl_r, rr_r;
  logic [RW-1:0]   ql_r, qr_r;
  logic [RW+2:0]   tl, tr, trl, trr;
  logic            gel, ger;

  // bring down two bits, compare against 4q+1
  always_comb begin
    tl  = {rl_i[RW:0], vl_i[VW-1:VW-2]};
    tr  = {rr_i[RW:0], vr_i[VW-1:VW-2]};
    trl = {1'b0, ql_i, 2'b01};
    trr = {1'b0, qr_i, 2'b01};
    gel = tl >= trl;
    ger = tr >= trr;
  end

  // control register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meta_r <= '0;
    end else if (en) begin
      meta_r <= meta_i;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (en) begin
      vl_r <= vl_i << 2;
      vr_r <= vr_i << 2;
      rl_r <= gel ? (RW+2)'(tl - trl) : tl[RW+1:0];
      rr_r <= ger ? (RW+2)'(tr - trr) : tr[RW+1:0];
      ql_r <= {ql_i[RW-2:0], gel};
      qr_r <= {qr_i[RW-2:0], ger};
    end
  end

  assign meta_o = meta_r;
  assign vl_o   = vl_r;
  assign rl_o   = rl_r;
  assign ql_o   = ql_r;
  assign vr_o   = vr_r;
  assign rr_o   = rr_r;
  assign qr_o   = qr_r;

endmodule

/* rtl/hanging_plotter_point_to_cord_lengths.sv */
// channel | ports                                   | beat
// in      | in_valid/in_stall, in_point_*, in_path_* | one drawing point
// out     | out_valid/out_stall, out_*               | one command
// cfg     | cfg_we, cfg_index, cfg_data              | one register write
//
// one point enters per cycle unless in_stall; it yields 1-3 beats, one per cycle
// stages are (16+F) divide cells, 3 arithmetic, (18+F) root cells and 1 output
// a point with pen commands holds the row of cells until its last beat is taken
// out_stall freezes every cell at once and raises in_stall while a beat waits
// rst_n is synchronous; it clears valid flags and loads register defaults
module hanging_plotter_point_to_cord_lengths #(
  parameter int FRACTION_BITS = hpc_pkg::FRACTION_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [hpc_pkg::PT_W-1:0]        in_point_x,
  input  logic [hpc_pkg::PT_W-1:0]        in_point_y,
  input  logic                            in_path_start,
  input  logic                            in_path_end,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [1:0]                      out_command,
  output logic [hpc_pkg::LEN_W-1:0]       out_left_length,
  output logic [hpc_pkg::LEN_W-1:0]       out_right_length,
  output logic                            out_run_last,
  input  logic                            cfg_we,
  input  logic [hpc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hpc_pkg::CFG_DAT_W-1:0]   cfg_data
);

  localparam int F  = FRACTION_BITS;
  localparam int PW = hpc_pkg::PT_W;
  localparam int DW = hpc_pkg::DIV_W;
  localparam int LW = hpc_pkg::LEN_W;
  localparam int NW = PW + F;
  localparam int XW = NW + 1;
  localparam int SW = 2 * XW + 1;
  localparam int RW = XW + 1;
  localparam int VW = 2 * RW;
  localparam int CW = (RW > LW) ? RW : LW;

  // configuration registers
  logic [DW-1:0] x_div_r, y_div_r;
  logic [PW-1:0] org_x_r, org_y_r, spacing_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_div_r   <= DW'(10);
      y_div_r   <= DW'(10);
      org_x_r   <= '0;
      org_y_r   <= '0;
      spacing_r <= PW'(1000);
    end else if (cfg_we) begin
      unique case (cfg_index)
        hpc_pkg::CFG_X_DIV:   x_div_r   <= cfg_data[DW-1:0];
        hpc_pkg::CFG_Y_DIV:   y_div_r   <= cfg_data[DW-1:0];
        hpc_pkg::CFG_ORG_X:   org_x_r   <= cfg_data;
        hpc_pkg::CFG_ORG_Y:   org_y_r   <= cfg_data;
        hpc_pkg::CFG_SPACING: spacing_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // zero divisor acts as one
  logic [DW-1:0] dvx, dvy;
  assign dvx = (x_div_r == '0) ? DW'(1) : x_div_r;
  assign dvy = (y_div_r == '0) ? DW'(1) : y_div_r;

  // whole row advances together
  logic en;
  assign in_stall = !en;

  // divide row
  hpc_pkg::meta_t dmeta [NW+1];
  logic [NW-1:0]  dnx [NW+1];
  logic [NW-1:0]  dqx [NW+1];
  logic [NW-1:0]  dny [NW+1];
  logic [NW-1:0]  dqy [NW+1];
  logic [DW-1:0]  drx [NW+1];
  logic [DW-1:0]  dry [NW+1];

  assign dmeta[0] = '{valid: in_valid, start: in_path_start, stop: in_path_end};
  assign dnx[0]   = NW'(in_point_x) << F;
  assign dny[0]   = NW'(in_point_y) << F;
  assign dqx[0]   = '0;
  assign dqy[0]   = '0;
  assign drx[0]   = '0;
  assign dry[0]   = '0;

  for (genvar i = 0; i < NW; i++) begin : g_div
    hpc_div_cell #(.NW(NW)) u_cell (
      .clk, .rst_n, .en,
      .meta_i(dmeta[i]), .nx_i(dnx[i]), .rx_i(drx[i]), .qx_i(dqx[i]),
      .ny_i(dny[i]), .ry_i(dry[i]), .qy_i(dqy[i]), .dvx, .dvy,
      .meta_o(dmeta[i+1]), .nx_o(dnx[i+1]), .rx_o(drx[i+1]), .qx_o(dqx[i+1]),
      .ny_o(dny[i+1]), .ry_o(dry[i+1]), .qy_o(dqy[i+1])
    );
  end

  // offset and distance to right anchor
  hpc_pkg::meta_t m1_r, m2_r, m3_r;
  logic [XW-1:0] x_r, y_r, dx_r;
  logic [XW-1:0] x_nxt, y_nxt, anchor;

  always_comb begin
    x_nxt  = XW'(dqx[NW]) + (XW'(org_x_r) << F);
    y_nxt  = XW'(dqy[NW]) + (XW'(org_y_r) << F);
    anchor = XW'(spacing_r) << F;
  end

  // squares, then sums
  logic [2*XW-1:0] xx_r, yy_r, dd_r;
  logic [SW-1:0]   sl_r, sr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_r <= '0;
      m2_r <= '0;
      m3_r <= '0;
    end else if (en) begin
      m1_r <= dmeta[NW];
      m2_r <= m1_r;
      m3_r <= m2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r  <= x_nxt;
      y_r  <= y_nxt;
      dx_r <= (anchor >= x_nxt) ? (anchor - x_nxt) : (x_nxt - anchor);
      xx_r <= x_r * x_r;
      yy_r <= y_r * y_r;
      dd_r <= dx_r * dx_r;
      sl_r <= SW'(xx_r) + SW'(yy_r);
      sr_r <= SW'(dd_r) + SW'(yy_r);
    end
  end

  // root row
  hpc_pkg::meta_t smeta [RW+1];
  logic [VW-1:0]  svl [RW+1];
  logic [VW-1:0]  svr [RW+1];
  logic [RW+1:0]  srl [RW+1];
  logic [RW+1:0]  srr [RW+1];
  logic [RW-1:0]  sql [RW+1];
  logic [RW-1:0]  sqr [RW+1];

  assign smeta[0] = m3_r;
  assign svl[0]   = VW'(sl_r);
  assign svr[0]   = VW'(sr_r);
  assign srl[0]   = '0;
  assign srr[0]   = '0;
  assign sql[0]   = '0;
  assign sqr[0]   = '0;

  for (genvar i = 0; i < RW; i++) begin : g_sqrt
    hpc_sqrt_cell #(.RW(RW)) u_cell (
      .clk, .rst_n, .en,
      .meta_i(smeta[i]), .vl_i(svl[i]), .rl_i(srl[i]), .ql_i(sql[i]),
      .vr_i(svr[i]), .rr_i(srr[i]), .qr_i(sqr[i]),
      .meta_o(smeta[i+1]), .vl_o(svl[i+1]), .rl_o(srl[i+1]), .ql_o(sql[i+1]),
      .vr_o(svr[i+1]), .rr_o(srr[i+1]), .qr_o(sqr[i+1])
    );
  end

  // saturate lengths
  logic [LW-1:0] len_l, len_r;
  always_comb begin
    len_l = (CW'(sql[RW]) > CW'(hpc_pkg::LEN_MAX)) ? hpc_pkg::LEN_MAX : LW'(sql[RW]);
    len_r = (CW'(sqr[RW]) > CW'(hpc_pkg::LEN_MAX)) ? hpc_pkg::LEN_MAX : LW'(sqr[RW]);
  end

  // output sequencer: move, optional pen down, optional pen up
  logic           ov_r, os_r, oe_r;
  hpc_pkg::cmd_t  phase_r, phase_nxt;
  logic [LW-1:0]  ol_r, or_r;
  logic           last, take;

  always_comb begin
    unique case (phase_r)
      hpc_pkg::CMD_MOVE:     last = !os_r && !oe_r;
      hpc_pkg::CMD_PEN_DOWN: last = !oe_r;
      default:               last = 1'b1;
    endcase
    phase_nxt = (phase_r == hpc_pkg::CMD_MOVE && os_r) ? hpc_pkg::CMD_PEN_DOWN
                                                       : hpc_pkg::CMD_PEN_UP;
    take = ov_r && !out_stall;
    en   = !ov_r || (take && last);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r    <= 1'b0;
      phase_r <= hpc_pkg::CMD_MOVE;
    end else if (en) begin
      ov_r    <= smeta[RW].valid;
      phase_r <= hpc_pkg::CMD_MOVE;
    end else if (take) begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      os_r <= smeta[RW].start;
      oe_r <= smeta[RW].stop;
      ol_r <= len_l;
      or_r <= len_r;
    end
  end

  assign out_valid        = ov_r;
  assign out_command      = phase_r;
  assign out_left_length  = (phase_r == hpc_pkg::CMD_MOVE) ? ol_r : '0;
  assign out_right_length = (phase_r == hpc_pkg::CMD_MOVE) ? or_r : '0;
  assign out_run_last     = last;

endmodule

/* rtl/hpc_checker.sv */
`include "hanging_plotter_point_to_cord_lengths_macros.svh"

// port-level checks on the plotter block
module hpc_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [1:0]                      out_command,
  input logic [hpc_pkg::LEN_W-1:0]       out_left_length,
  input logic [hpc_pkg::LEN_W-1:0]       out_right_length,
  input logic                            out_run_last
);

  // stalled beat holds
  `HPC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_command), "out beat changed under stall")

  // pen commands carry no lengths
  `HPC_ASSERT_NOW(a_pen_zero, out_valid && out_command != hpc_pkg::CMD_MOVE, out_left_length == '0 && out_right_length == '0, "pen command with nonzero length")

  // pen up always closes a point
  `HPC_ASSERT_NOW(a_up_last, out_valid && out_command == hpc_pkg::CMD_PEN_UP, out_run_last, "pen up not last beat")

  // an empty output never holds back input
  `HPC_ASSERT_NOW(a_no_stall, !out_valid, !in_stall, "input stalled with empty output")

  // a taken non-final beat is followed by a pen command
  `HPC_ASSERT_NEXT(a_follow, out_valid && !out_stall && !out_run_last, out_valid && out_command != hpc_pkg::CMD_MOVE, "missing pen beat")

endmodule

bind hanging_plotter_point_to_cord_lengths hpc_checker u_hpc_checker (.*);

/* tb/tb_hanging_plotter_point_to_cord_lengths.sv */
`timescale 1ns / 100ps

module tb_hanging_plotter_point_to_cord_lengths;

  localparam int FB = hpc_pkg::FRACTION_BITS;
  localparam int PW = hpc_pkg::PT_W;
  localparam int LW = hpc_pkg::LEN_W;
  localparam int IW = hpc_pkg::CFG_IDX_W;
  localparam int CDW = hpc_pkg::CFG_DAT_W;
  localparam int DRAIN_CYCLES = 70;

  typedef struct packed {
    logic [PW-1:0] x;
    logic [PW-1:0] y;
    logic          start;
    logic          stop;
  } point_t;

  typedef struct packed {
    hpc_pkg::cmd_t command;
    logic [LW-1:0] left;
    logic [LW-1:0] right;
    logic          last;
  } beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [PW-1:0] in_point_x = '0;
  logic [PW-1:0] in_point_y = '0;
  logic in_path_start = 1'b0;
  logic in_path_end = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_command;
  logic [LW-1:0] out_left_length;
  logic [LW-1:0] out_right_length;
  logic out_run_last;
  logic cfg_we = 1'b0;
  logic [IW-1:0] cfg_index = '0;
  logic [CDW-1:0] cfg_data = '0;

  // plotter geometry as the block should hold it
  logic [7:0]  geo_x_div = 8'd10;
  logic [7:0]  geo_y_div = 8'd10;
  logic [15:0] geo_org_x = 16'd0;
  logic [15:0] geo_org_y = 16'd0;
  logic [15:0] geo_spacing = 16'd1000;

  point_t point_q[$];
  beat_t  cmd_q[$];
  int     err_count = 0;
  int     points_sent = 0;
  int     beats_seen = 0;
  int     send_idle_pct = 0;
  int     recv_stall_pct = 0;
  logic   in_took = 1'b0;

  hanging_plotter_point_to_cord_lengths u_top (.*);

  always #10 clk = ~clk;

  // floor square root, bit by bit
  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned res, bit_w;
    res = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > v) bit_w >>= 2;
    while (bit_w != 0) begin
      if (v >= res + bit_w) begin
        v -= res + bit_w;
        res = (res >> 1) + bit_w;
      end else begin
        res >>= 1;
      end
      bit_w >>= 2;
    end
    return res;
  endfunction

  function automatic logic [LW-1:0] cord_len(longint unsigned a, longint unsigned b);
    longint unsigned r;
    r = root_floor(a * a + b * b);
    if (r > hpc_pkg::LEN_MAX) r = hpc_pkg::LEN_MAX;
    return r[LW-1:0];
  endfunction

  function automatic longint unsigned to_plotter(logic [15:0] raw, logic [7:0] dv,
                                                 logic [15:0] org);
    longint unsigned d;
    d = (dv == 0) ? 1 : dv;
    return ((longint'(raw) << FB) / d) + (longint'(org) << FB);
  endfunction

  // expected command beats for one point
  task automatic predict_commands(point_t p);
    longint unsigned px, py, anchor, dx;
    beat_t b;
    px = to_plotter(p.x, geo_x_div, geo_org_x);
    py = to_plotter(p.y, geo_y_div, geo_org_y);
    anchor = longint'(geo_spacing) << FB;
    dx = (anchor >= px) ? anchor - px : px - anchor;
    b.command = hpc_pkg::CMD_MOVE;
    b.left = cord_len(px, py);
    b.right = cord_len(dx, py);
    b.last = !(p.start || p.stop);
    cmd_q.push_back(b);
    if (p.start) begin
      b = '{hpc_pkg::CMD_PEN_DOWN, '0, '0, !p.stop};
      cmd_q.push_back(b);
    end
    if (p.stop) begin
      b = '{hpc_pkg::CMD_PEN_UP, '0, '0, 1'b1};
      cmd_q.push_back(b);
    end
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  // driver: next point at the falling edge
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
    if (!in_valid || in_took) begin
      if (rst_n && point_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        point_t p;
        p = point_q.pop_front();
        in_point_x <= p.x;
        in_point_y <= p.y;
        in_path_start <= p.start;
        in_path_end <= p.stop;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: check command beats, predict accepted points
  always @(posedge clk) begin
    in_took <= in_valid && !in_stall && rst_n;
    if (rst_n && out_valid && !out_stall) begin
      beats_seen++;
      if (cmd_q.size() == 0) begin
        report_mismatch("unexpected beat, command", out_command, -1);
      end else begin
        beat_t w;
        w = cmd_q.pop_front();
        if (out_command !== w.command) report_mismatch("command", out_command, w.command);
        if (out_left_length !== w.left) report_mismatch("left", out_left_length, w.left);
        if (out_right_length !== w.right) report_mismatch("right", out_right_length, w.right);
        if (out_run_last !== w.last) report_mismatch("run_last", out_run_last, w.last);
      end
    end
    if (rst_n && in_valid && !in_stall) begin
      points_sent++;
      predict_commands('{in_point_x, in_point_y, in_path_start, in_path_end});
    end
  end

  task automatic write_reg(logic [IW-1:0] idx, logic [CDW-1:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      hpc_pkg::CFG_X_DIV:   geo_x_div = val[7:0];
      hpc_pkg::CFG_Y_DIV:   geo_y_div = val[7:0];
      hpc_pkg::CFG_ORG_X:   geo_org_x = val;
      hpc_pkg::CFG_ORG_Y:   geo_org_y = val;
      hpc_pkg::CFG_SPACING: geo_spacing = val;
      default: ;
    endcase
  endtask

  task automatic set_geometry(int xd, int yd, int ox, int oy, int sp);
    write_reg(hpc_pkg::CFG_X_DIV, CDW'(xd));
    write_reg(hpc_pkg::CFG_Y_DIV, CDW'(yd));
    write_reg(hpc_pkg::CFG_ORG_X, CDW'(ox));
    write_reg(hpc_pkg::CFG_ORG_Y, CDW'(oy));
    write_reg(hpc_pkg::CFG_SPACING, CDW'(sp));
  endtask

  // wait until every point went in and every command came out
  task automatic drain_all();
    while (point_q.size() > 0 || in_valid || cmd_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_coord();
    case ($urandom_range(9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // mostly well formed paths, some loose flags
  task automatic queue_paths(int n);
    int k, len;
    point_t p;
    k = 0;
    while (k < n) begin
      if ($urandom_range(4) == 0) begin
        p = '{pick_coord(), pick_coord(), 1'($urandom), 1'($urandom)};
        point_q.push_back(p);
        k++;
      end else begin
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++) begin
          p = '{pick_coord(), pick_coord(), i == 0, i == len - 1};
          point_q.push_back(p);
        end
        k += len;
      end
    end
  endtask

  task automatic set_idle(int s, int r);
    send_idle_pct = s;
    recv_stall_pct = r;
  endtask

  initial begin
    point_t p;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: reset geometry, field extremes and flag combinations
    p = '{16'h0000, 16'h0000, 1'b0, 1'b0}; point_q.push_back(p);
    p = '{16'hFFFF, 16'hFFFF, 1'b0, 1'b0}; point_q.push_back(p);
    p = '{16'hFFFF, 16'h0000, 1'b1, 1'b0}; point_q.push_back(p);
    p = '{16'h0000, 16'hFFFF, 1'b0, 1'b1}; point_q.push_back(p);
    p = '{16'h2710, 16'h1234, 1'b1, 1'b1}; point_q.push_back(p);
    p = '{16'h5555, 16'hAAAA, 1'b1, 1'b0}; point_q.push_back(p);
    p = '{16'hAAAA, 16'h5555, 1'b0, 1'b1}; point_q.push_back(p);
    drain_all();

    // smallest divisors and spacing; point right of the right anchor
    set_geometry(1, 1, 0, 0, 1);
    p = '{16'hFFFF, 16'hFFFF, 1'b1, 1'b1}; point_q.push_back(p);
    p = '{16'h0001, 16'h0000, 1'b0, 1'b0}; point_q.push_back(p);
    p = '{16'h0000, 16'h0001, 1'b1, 1'b0}; point_q.push_back(p);
    drain_all();

    // largest geometry values; points at both extremes
    set_geometry(255, 255, 65535, 65535, 65535);
    p = '{16'hFFFF, 16'hFFFF, 1'b1, 1'b1}; point_q.push_back(p);
    p = '{16'h0000, 16'h0000, 1'b0, 1'b0}; point_q.push_back(p);
    drain_all();

    // zero divisors act as one
    set_geometry(0, 0, 65535, 0, 1);
    p = '{16'hFFFF, 16'hFFFF, 1'b0, 1'b1}; point_q.push_back(p);
    p = '{16'h8000, 16'h0001, 1'b1, 1'b0}; point_q.push_back(p);
    drain_all();

    // random phases cycling through the idle patterns
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: set_idle(0, 0);
        1: set_idle(50, 0);
        2: set_idle(0, 50);
        default: set_idle(6, 6);
      endcase
      case (ph)
        0: set_geometry(10, 10, 0, 0, 1000);
        1: set_geometry(1, 255, 0, 65535, 65535);
        2: set_geometry(255, 1, 65535, 0, 1);
        3: set_geometry(0, 7, 300, 20, 600);
        default: set_geometry($urandom_range(255), $urandom_range(255),
                              $urandom_range(65535), $urandom_range(65535),
                              $urandom_range(1, 65535));
      endcase
      queue_paths(25);
      // sender holds back until every command is out
      while (point_q.size() > 0 || in_valid) @(posedge clk);
      while (cmd_q.size() > 0) @(posedge clk);
      queue_paths(25);
      drain_all();
    end

    $display("covered %0d points and %0d command beats over 12 geometry settings",
             points_sent, beats_seen);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // run limit
  initial begin
    #5000000;
    $display("timeout with %0d commands pending", cmd_q.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
